/* design/snt_pkg.sv */
// ----------------------------------------------------------------------------
// snt_pkg
// Shared types, codes and helpers for the sigmoid neuron training block.
// ----------------------------------------------------------------------------
package snt_pkg;

    // item command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_TRAIN  = 2'd2;

    // configuration register indexes
    localparam logic REG_LEARN_RATE  = 1'b0;
    localparam logic REG_HIDDEN_MODE = 1'b1;

    localparam logic [11:0] LEARN_RATE_RST = 12'd410;

    // result kinds
    localparam logic KIND_OUTPUT = 1'b0;
    localparam logic KIND_WERROR = 1'b1;

    // weight and sample held by one cell
    typedef struct packed {
        logic signed [15:0] weight;
        logic signed [15:0] sample;
    } data_t;

    // broadcast control to every cell
    typedef struct packed {
        logic               shift;
        logic               load_en;
        logic [3:0]         load_idx;
        logic signed [15:0] load_val;
        logic               clr_en;
    } ctrl_t;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
        logic signed [15:0] r;
        if (x > 48'sd32767)
            r = 16'sh7fff;
        else if (x < -48'sd32768)
            r = 16'sh8000;
        else
            r = x[15:0];
        return r;
    endfunction

endpackage

/* design/snt_cell.sv */
// ----------------------------------------------------------------------------
// snt_cell
// One link of the weight/sample ring: holds one weight and one sample,
// applies loads, clears and head writes, and passes its pair on when the
// ring rotates.
// ----------------------------------------------------------------------------
module snt_cell #(
    parameter int NUM_INPUTS = 16,
    parameter int POS        = 0,
    parameter int IW         = 4,
    parameter int CW         = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  snt_pkg::ctrl_t      ctrl,
    input  logic [IW-1:0]       head_idx,
    input  logic [CW-1:0]       clr_from,
    input  logic                wr_sample,
    input  logic signed [15:0]  sample_in,
    input  logic                wr_weight,
    input  logic signed [15:0]  weight_in,
    input  snt_pkg::data_t      from_next,
    output snt_pkg::data_t      pass,
    output snt_pkg::data_t      held
);

    logic signed [15:0] weight_reg;
    logic signed [15:0] sample_reg;
    snt_pkg::data_t     data_next;
    logic [IW:0]        pos_sum;
    logic [IW-1:0]      log_idx;

    // logical index of the pair held here
    always_comb
    begin
        pos_sum = {1'b0, head_idx} + (IW+1)'(POS);
        if (pos_sum >= (IW+1)'(NUM_INPUTS))
            log_idx = IW'(pos_sum - (IW+1)'(NUM_INPUTS));
        else
            log_idx = IW'(pos_sum);
    end

    always_comb
    begin
        pass.weight = weight_reg;
        pass.sample = sample_reg;
        if (ctrl.load_en && (int'(log_idx) == int'(ctrl.load_idx)))
            pass.weight = ctrl.load_val;
        if (wr_weight)
            pass.weight = weight_in;
        if (wr_sample)
            pass.sample = sample_in;
        else if (ctrl.clr_en && (int'(log_idx) >= int'(clr_from)))
            pass.sample = '0;
        data_next = ctrl.shift ? from_next : pass;
    end

    assign held.weight = weight_reg;
    assign held.sample = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_reg <= '0;
        else
            sample_reg <= data_next.sample;
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= data_next.weight;
    end

endmodule

/* design/snt_sigmoid.sv */
// ----------------------------------------------------------------------------
// snt_sigmoid
// Sigmoid lookup: clamps the Q16.24 sum to [-8,8), picks the bin and reads
// the Q1.12 table. Two register stages (bin, table read).
// ----------------------------------------------------------------------------
module snt_sigmoid #(
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic signed [39:0] sum,
    output logic [12:0]        prob
);

    localparam int KW = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int PW = 28 + KW + 1;

    typedef logic [12:0] rom_t [SIGMOID_TABLE_DEPTH];

    // restoring long division, only used while the table is built
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned dvs);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, dvs})
            begin
                rem    = rem - {1'b0, dvs};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^-x via Taylor series of e^-(x/8), squared three times
    function automatic logic [12:0] sig_entry(input int k);
        longint          m;
        longint unsigned am;
        longint unsigned u;
        longint unsigned e;
        longint unsigned term;
        longint unsigned den;
        longint unsigned v;
        longint unsigned i;
        m = 2 * longint'(k) + 1 - longint'(SIGMOID_TABLE_DEPTH);
        if (m < 0)
            am = -m;
        else
            am = m;
        u = udiv64(am << 32, 64'(SIGMOID_TABLE_DEPTH));
        if (u > 64'hffff_ffff)
            u = 64'hffff_ffff;
        e    = 64'd1 << 32;
        term = 64'd1 << 32;
        for (i = 1; i <= 20; i++)
        begin
            term = udiv64((term * u) >> 32, i);
            if (i[0])
                e = (term > e) ? 64'd0 : e - term;
            else
                e = e + term;
        end
        for (i = 0; i < 3; i++)
        begin
            if (e > 64'hffff_ffff)
                e = 64'hffff_ffff;
            e = (e * e) >> 32;
        end
        den = (64'd1 << 32) + e;
        v = udiv64((64'd4096 << 32) + (den >> 1), den);
        if (m < 0)
            v = 64'd4096 - v;
        return v[12:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < SIGMOID_TABLE_DEPTH; k++)
            r[k] = sig_entry(k);
        return r;
    endfunction

    localparam rom_t SIG_ROM = build_rom();

    logic [27:0]   offset;
    logic [PW-1:0] bin_prod;
    logic [KW-1:0] bin_reg;
    logic [12:0]   prob_reg;

    // in range when bits 39..27 are all equal
    always_comb
    begin
        if ((sum[39:27] == '0) || (sum[39:27] == '1))
            offset = {~sum[27], sum[26:0]};
        else if (sum[39])
            offset = '0;
        else
            offset = '1;
        bin_prod = PW'(offset) * PW'(SIGMOID_TABLE_DEPTH);
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_prod[28 +: KW];
        prob_reg <= SIG_ROM[bin_reg];
    end

    assign prob = prob_reg;

endmodule

/* design/sigmoid_neuron_train_top.sv */
// ----------------------------------------------------------------------------
// sigmoid_neuron_train_top
// Single sigmoid neuron, Q4.12, with delta-rule training.
// ----------------------------------------------------------------------------
// Weights and samples live in a ring of NUM_INPUTS cells; the head cell feeds
// one multiply-accumulate and one update unit, and the ring rotates one place
// a cycle while it shifts. A load item writes one weight and leaves the block
// idle. A vector streams at one sample a cycle; the sample marked last then
// passes through accumulate, bin, table read and output (held while the output
// is stalled), turns the ring back to index 0 (no turn if the samples held
// number 0 or NUM_INPUTS) and returns to idle.
// A train item forms the node error and scales it by the learn rate, brings
// index 0 to the head and walks the ring in NUM_INPUTS steps (each writes one
// weight; the first min(NUM_INPUTS, 16) emit a weighted error and are held
// while the output is stalled), restores the ring to the current sample
// position and returns to idle. Unused command 3 is accepted and ignored.
// ----------------------------------------------------------------------------
module sigmoid_neuron_train_top #(
    parameter int NUM_INPUTS          = 16,
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [11:0]        cfg_wdata,
    // input items
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [3:0]         index,
    input  logic signed [15:0] value,
    input  logic               last,
    // result items
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [3:0]         slot,
    output logic signed [15:0] result_value,
    output logic               final_res
);

    localparam int IW   = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int CW   = $clog2(NUM_INPUTS + 1);
    localparam int EMIT = (NUM_INPUTS < 16) ? NUM_INPUTS : 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_BIN,
        S_ROM,
        S_EMIT,
        S_TERR1,
        S_TERR2,
        S_ALIGN0,
        S_WALK,
        S_ALIGNC
    } state_t;

    state_t              state_reg, state_next;
    logic [IW-1:0]       head_reg, head_next, head_inc;
    logic [CW-1:0]       count_reg, count_next, cnt_new;
    logic [IW-1:0]       cnt_mod;
    logic [CW-1:0]       step_reg, step_next;
    logic [11:0]         learn_rate_reg;
    logic                hidden_mode_reg;
    logic signed [39:0]  sum_reg, sum_next;
    logic signed [40:0]  sum_wide;
    logic                prod_valid_reg;
    logic signed [31:0]  prod_reg;
    logic [12:0]         neuron_out_reg;
    logic [10:0]         d_reg;
    logic signed [16:0]  diff_reg;
    logic signed [15:0]  err_reg;
    logic signed [28:0]  er_reg;
    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [3:0]          out_slot_reg;
    logic signed [15:0]  out_value_reg;
    logic                out_final_reg;

    logic                prod_load, train_load, err_load, er_load, sum_clear;
    logic                out_load, out_free, emit_here;
    logic                out_kind_next, out_final_next;
    logic [3:0]          out_slot_next;
    logic signed [15:0]  out_value_next;
    logic [12:0]         prob;
    logic [25:0]         d_prod;
    logic signed [16:0]  diff_calc;
    logic signed [28:0]  de_prod;
    logic signed [28:0]  er_prod;
    logic signed [31:0]  we_prod;
    logic signed [44:0]  upd_prod;
    logic signed [21:0]  new_weight;
    logic signed [15:0]  head_weight_in;
    logic                head_wr_sample, head_wr_weight;
    logic [CW-1:0]       clr_from;
    snt_pkg::ctrl_t      ctrl;
    snt_pkg::data_t      pass_w [NUM_INPUTS];
    snt_pkg::data_t      held_w [NUM_INPUTS];

    // ---------------- cell ring ----------------
    for (genvar p = 0; p < NUM_INPUTS; p++)
    begin : g_cell
        snt_cell #(
            .NUM_INPUTS (NUM_INPUTS),
            .POS        (p),
            .IW         (IW),
            .CW         (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .head_idx  (head_reg),
            .clr_from  (clr_from),
            .wr_sample ((p == 0) ? head_wr_sample : 1'b0),
            .sample_in (value),
            .wr_weight ((p == 0) ? head_wr_weight : 1'b0),
            .weight_in (head_weight_in),
            .from_next (pass_w[(p == NUM_INPUTS - 1) ? 0 : p + 1]),
            .pass      (pass_w[p]),
            .held      (held_w[p])
        );
    end

    snt_sigmoid #(
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_sigmoid (
        .clk  (clk),
        .sum  (sum_reg),
        .prob (prob)
    );

    // ---------------- arithmetic ----------------
    always_comb
    begin
        d_prod    = 26'(neuron_out_reg) * 26'(13'd4096 - neuron_out_reg);
        diff_calc = hidden_mode_reg ? 17'(value)
                                    : 17'(value) - $signed({4'b0, neuron_out_reg});
        de_prod   = $signed({1'b0, d_reg}) * 29'(diff_reg);
        er_prod   = 29'(err_reg) * $signed({1'b0, learn_rate_reg});
        we_prod   = 32'(err_reg) * 32'(held_w[0].weight);
        upd_prod  = 45'(er_reg) * 45'(held_w[0].sample);
        new_weight = 22'(held_w[0].weight) + 22'(upd_prod >>> 24);
        head_weight_in = snt_pkg::sat16(48'(new_weight));
        sum_wide  = 41'(sum_reg) + 41'(prod_reg);
        if (sum_wide > 41'sh7f_ffff_ffff)
            sum_next = 40'sh7f_ffff_ffff;
        else if (sum_wide < -41'sh80_0000_0000)
            sum_next = -40'sh80_0000_0000;
        else
            sum_next = sum_wide[39:0];
    end

    // ---------------- sequencer ----------------
    assign head_inc = (head_reg == IW'(NUM_INPUTS - 1)) ? '0 : head_reg + 1'b1;
    assign cnt_mod  = (count_reg == CW'(NUM_INPUTS)) ? '0 : IW'(count_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign emit_here = (step_reg < CW'(EMIT));
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        cnt_new        = count_reg;
        ctrl           = '0;
        ctrl.load_idx  = index;
        ctrl.load_val  = value;
        clr_from       = '0;
        head_wr_sample = 1'b0;
        head_wr_weight = 1'b0;
        prod_load      = 1'b0;
        train_load     = 1'b0;
        err_load       = 1'b0;
        er_load        = 1'b0;
        sum_clear      = 1'b0;
        out_load       = 1'b0;
        out_kind_next  = snt_pkg::KIND_OUTPUT;
        out_slot_next  = '0;
        out_value_next = 16'(neuron_out_reg);
        out_final_next = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        snt_pkg::CMD_LOAD:
                            ctrl.load_en = 1'b1;
                        snt_pkg::CMD_SAMPLE:
                        begin
                            if (count_reg < CW'(NUM_INPUTS))
                            begin
                                head_wr_sample = 1'b1;
                                ctrl.shift     = 1'b1;
                                head_next      = head_inc;
                                prod_load      = 1'b1;
                                cnt_new        = count_reg + 1'b1;
                            end
                            count_next = cnt_new;
                            if (last)
                            begin
                                ctrl.clr_en = 1'b1;
                                clr_from    = cnt_new;
                                count_next  = '0;
                                state_next  = S_ACC;
                            end
                        end
                        snt_pkg::CMD_TRAIN:
                        begin
                            train_load = 1'b1;
                            state_next = S_TERR1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ACC:
                state_next = S_BIN;
            S_BIN:
                state_next = S_ROM;
            S_ROM:
                state_next = S_EMIT;
            S_EMIT:
            begin
                // sum held until the output is taken so the table read stays put
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_value_next = 16'(prob);
                    sum_clear      = 1'b1;
                    state_next     = S_ALIGNC;
                end
            end
            S_TERR1:
            begin
                err_load   = 1'b1;
                state_next = S_TERR2;
            end
            S_TERR2:
            begin
                er_load    = 1'b1;
                state_next = S_ALIGN0;
            end
            S_ALIGN0:
            begin
                if (head_reg == '0)
                begin
                    step_next  = '0;
                    state_next = S_WALK;
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    head_next  = head_inc;
                end
            end
            S_WALK:
            begin
                if (!emit_here || out_free)
                begin
                    head_wr_weight = 1'b1;
                    ctrl.shift     = 1'b1;
                    head_next      = head_inc;
                    step_next      = step_reg + 1'b1;
                    if (emit_here)
                    begin
                        out_load       = 1'b1;
                        out_kind_next  = snt_pkg::KIND_WERROR;
                        out_slot_next  = 4'(step_reg);
                        out_value_next = snt_pkg::sat16(48'(we_prod >>> 12));
                        out_final_next = (step_reg == CW'(EMIT - 1));
                    end
                    if (step_reg == CW'(NUM_INPUTS - 1))
                        state_next = S_ALIGNC;
                end
            end
            S_ALIGNC:
            begin
                if (head_reg == cnt_mod)
                    state_next = S_IDLE;
                else
                begin
                    ctrl.shift = 1'b1;
                    head_next  = head_inc;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            step_reg        <= '0;
            sum_reg         <= '0;
            prod_valid_reg  <= 1'b0;
            neuron_out_reg  <= '0;
            out_valid_reg   <= 1'b0;
            learn_rate_reg  <= snt_pkg::LEARN_RATE_RST;
            hidden_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            prod_valid_reg <= prod_load;
            if (sum_clear)
                sum_reg <= '0;
            else if (prod_valid_reg)
                sum_reg <= sum_next;
            if (out_load && (state_reg == S_EMIT))
                neuron_out_reg <= prob;
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    snt_pkg::REG_LEARN_RATE:  learn_rate_reg  <= cfg_wdata;
                    snt_pkg::REG_HIDDEN_MODE: hidden_mode_reg <= cfg_wdata[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (prod_load)
            prod_reg <= 32'(value) * 32'(held_w[0].weight);
        if (train_load)
        begin
            d_reg    <= d_prod[22:12];
            diff_reg <= diff_calc;
        end
        if (err_load)
            err_reg <= snt_pkg::sat16(48'(de_prod >>> 12));
        if (er_load)
            er_reg <= er_prod;
        if (out_load)
        begin
            out_kind_reg  <= out_kind_next;
            out_slot_reg  <= out_slot_next;
            out_value_reg <= out_value_next;
            out_final_reg <= out_final_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign slot         = out_slot_reg;
    assign result_value = out_value_reg;
    assign final_res    = out_final_reg;

endmodule
